// ===== rtl/pfs_pkg.sv =====
// Package for the prime factor sum block.
// Holds widths, register map and reset values shared by all modules.
// Depends on nothing.
`timescale 1ns / 1ps

package pfs_pkg;

	localparam int NUMBER_WIDTH_DEF = 16;
	localparam int SUM_WIDTH        = 17;
	localparam int OUT_TDATA_W      = ((SUM_WIDTH + 7) / 8) * 8;

	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;

	localparam logic REG_IDX_ADD_ONE = 1'b0;
	localparam logic ADD_ONE_RESET   = 1'b1;

endpackage

// ===== rtl/pfs_div.sv =====
// Iterative restoring divider, one quotient bit per cycle.
// Shared arithmetic unit of the prime factor sum block; uses pfs_pkg.
`timescale 1ns / 1ps

module pfs_div #(
	parameter int W = pfs_pkg::NUMBER_WIDTH_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] dividend,
	input  logic [W-1:0] divisor,
	output logic         done,
	output logic [W-1:0] quo,
	output logic [W-1:0] rem
);
	import pfs_pkg::*;

	localparam int CW = $clog2(W + 1);

	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [W-1:0]  rem_q;
	logic [W-1:0]  quo_q;
	logic [W-1:0]  dvs_q;
	logic [W:0]    trial;
	logic [W:0]    diff;
	logic          fits;

	assign trial = {rem_q, quo_q[W-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign fits  = ~diff[W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? diff[W-1:0] : trial[W-1:0];
			quo_q <= {quo_q[W-2:0], fits};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;
	assign rem  = rem_q;

endmodule

// ===== rtl/pfs_cfg.sv =====
// APB register file of the prime factor sum block: the add_one register.
// Uses pfs_pkg for the address map and reset value.
`timescale 1ns / 1ps

module pfs_cfg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [pfs_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [pfs_pkg::APB_DATA_W-1:0] pwdata,
	output logic [pfs_pkg::APB_DATA_W-1:0] prdata,
	output logic                           pready,
	output logic                           add_one
);
	import pfs_pkg::*;

	logic add_one_q;
	logic sel_add_one;

	assign sel_add_one = (paddr[APB_ADDR_W-1:2] == REG_IDX_ADD_ONE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			add_one_q <= ADD_ONE_RESET;
		end else if (psel && penable && pwrite && sel_add_one) begin
			add_one_q <= pwdata[0];
		end
	end

	assign prdata  = sel_add_one ? {{(APB_DATA_W-1){1'b0}}, add_one_q} : '0;
	assign pready  = 1'b1;
	assign add_one = add_one_q;

endmodule

// ===== rtl/prime_factor_sum.sv =====
// Top level of the prime factor sum block: sequencer, output register, APB port.
// Instantiates pfs_div and pfs_cfg; uses pfs_pkg.
//
// The block factors one number per transaction by trial division and returns the
// sum of its prime factors with multiplicity, plus one when add_one is set; a zero
// input returns sum zero with invalid high. All divisions run on one shared
// restoring divider, and one trial is one division plus the sequencer's decision
// and restart. An item needs about (sqrt(n) + number of prime factors) trials;
// a zero input skips the divider. The input is not ready while an item is in
// work, but a finished result may wait in the output register while the next
// item is taken.
`timescale 1ns / 1ps

module prime_factor_sum #(
	parameter int NUMBER_WIDTH = pfs_pkg::NUMBER_WIDTH_DEF,
	localparam int IN_W = ((NUMBER_WIDTH + 7) / 8) * 8
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [IN_W-1:0]                 s_tdata,   // number
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [pfs_pkg::OUT_TDATA_W-1:0] m_tdata,   // factor_sum
	output logic [0:0]                      m_tuser,   // invalid
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [pfs_pkg::APB_ADDR_W-1:0]  paddr,
	input  logic [pfs_pkg::APB_DATA_W-1:0]  pwdata,
	output logic [pfs_pkg::APB_DATA_W-1:0]  prdata,
	output logic                            pready
);
	import pfs_pkg::*;

	localparam int NW = NUMBER_WIDTH;
	localparam int TW = NW + 1;
	localparam int EW = (TW > SUM_WIDTH) ? TW : SUM_WIDTH;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_RUN  = 2'd1;
	localparam logic [1:0] S_FIN  = 2'd2;

	logic [1:0]           state_q;
	logic [NW-1:0]        m_q;
	logic [NW-1:0]        d_q;
	logic [TW-1:0]        total_q;
	logic                 start_q;
	logic                 inv_q;
	logic                 out_vld_q;
	logic [SUM_WIDTH-1:0] out_sum_q;
	logic                 out_inv_q;

	logic                 add_one;
	logic                 div_done;
	logic [NW-1:0]        div_quo;
	logic [NW-1:0]        div_rem;
	logic [NW-1:0]        num_in;
	logic                 in_acc;
	logic                 out_free;
	logic [EW-1:0]        sum_ext;

	pfs_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.add_one (add_one)
	);

	pfs_div #(.W(NW)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start_q),
		.dividend (m_q),
		.divisor  (d_q),
		.done     (div_done),
		.quo      (div_quo),
		.rem      (div_rem)
	);

	assign num_in   = s_tdata[NW-1:0];
	assign s_tready = (state_q == S_IDLE);
	assign in_acc   = s_tvalid && s_tready;
	assign out_free = !out_vld_q || m_tready;
	assign sum_ext  = EW'(total_q) + EW'(add_one);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			start_q   <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			start_q <= 1'b0;
			if (m_tready) begin
				out_vld_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						if (num_in == '0) begin
							state_q <= S_FIN;
						end else begin
							state_q <= S_RUN;
							start_q <= 1'b1;
						end
					end
				end
				S_RUN: begin
					if (div_done) begin
						if (d_q > div_quo) begin
							state_q <= S_FIN;
						end else begin
							start_q <= 1'b1;
						end
					end
				end
				S_FIN: begin
					if (out_free) begin
						out_vld_q <= 1'b1;
						state_q   <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					m_q     <= num_in;
					d_q     <= NW'(2);
					total_q <= '0;
					inv_q   <= (num_in == '0);
				end
			end
			S_RUN: begin
				if (div_done) begin
					if (d_q > div_quo) begin
						if (m_q > NW'(1)) begin
							total_q <= total_q + TW'(m_q);
						end
					end else if (div_rem == '0) begin
						total_q <= total_q + TW'(d_q);
						m_q     <= div_quo;
					end else begin
						d_q <= d_q + NW'(1);
					end
				end
			end
			S_FIN: begin
				if (out_free) begin
					out_inv_q <= inv_q;
					out_sum_q <= inv_q ? '0 : sum_ext[SUM_WIDTH-1:0];
				end
			end
			default: begin
			end
		endcase
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = OUT_TDATA_W'(out_sum_q);
	assign m_tuser  = out_inv_q;

`ifndef ASSERT_OFF
	a_start_divisor: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && num_in != '0) |=> (state_q == S_RUN && d_q == NW'(2) && start_q))
		else $error("trial division did not start at divisor two");

	a_div_min: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RUN) |-> (d_q >= NW'(2)))
		else $error("trial divisor fell below two");

	a_done_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == S_RUN))
		else $error("divider finished outside of a factoring run");

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[0]) |-> (m_tdata == '0))
		else $error("invalid result carries a nonzero sum");
`endif

endmodule

// ===== dv/prime_factor_sum_tb.sv =====
// Testbench for prime_factor_sum: streams numbers in, checks each factor sum against a predictor.
// Covers the add_one register over APB, input and output idling, and output back-pressure.
// Depends on pfs_pkg and the prime_factor_sum RTL.
`timescale 1ns / 1ps

module prime_factor_sum_tb;
	import pfs_pkg::*;

	localparam int NUM_W       = NUMBER_WIDTH_DEF;
	localparam int IN_W        = ((NUM_W + 7) / 8) * 8;
	localparam int ADDR_W      = APB_ADDR_W;
	localparam int REG_IDX_UNUSED = 1;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int HOLD_OFF_CYCLES = 2000;
	localparam int TAIL_CYCLES     = 100;
	localparam int RANDOM_PER_PHASE = 28;

	typedef struct packed {
		logic [SUM_WIDTH-1:0] factor_sum;
		logic                 invalid;
	} factor_result_t;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    s_tvalid = 1'b0;
	logic                    s_tready;
	logic [IN_W-1:0]         s_tdata = '0;         // number
	logic                    m_tvalid;
	logic                    m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0]  m_tdata;              // factor_sum
	logic [0:0]              m_tuser;              // invalid
	logic                    psel = 1'b0;
	logic                    penable = 1'b0;
	logic                    pwrite = 1'b0;
	logic [ADDR_W-1:0]       paddr = '0;
	logic [APB_DATA_W-1:0]   pwdata = '0;
	logic [APB_DATA_W-1:0]   prdata;
	logic                    pready;

	factor_result_t pending_sums[$];
	logic           add_one_model = ADD_ONE_RESET;
	int             error_count = 0;
	int             idle_cycles = 0;
	int             tx_idle_pct = 0;
	int             rx_stall_pct = 0;
	int             hold_req_id = 0;
	int             hold_seen_id = 0;
	int             hold_left = 0;

	prime_factor_sum #(.NUMBER_WIDTH(NUM_W)) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic factor_result_t predict_factor_sum(input logic [IN_W-1:0] number,
			input logic add_one);
		factor_result_t r;
		int unsigned    m;
		int unsigned    d;
		int unsigned    total;
		m = number;
		total = 0;
		d = 2;
		r.invalid = (m == 0);
		r.factor_sum = '0;
		if (m != 0) begin
			while (d * d <= m) begin
				while (m % d == 0) begin
					total += d;
					m /= d;
				end
				d++;
			end
			if (m > 1)
				total += m;
			total += add_one;
			r.factor_sum = SUM_WIDTH'(total);
		end
		return r;
	endfunction

	// The receiver owns m_tready; a long hold-off is requested by bumping hold_req_id.
	always @(posedge clk) begin
		if (hold_req_id != hold_seen_id) begin
			hold_seen_id = hold_req_id;
			hold_left = HOLD_OFF_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= rx_stall_pct);
		end
	end

	always @(posedge clk) begin
		factor_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_sums.size() == 0) begin
				$error("unexpected transaction: factor_sum %0d, invalid %0d",
					m_tdata[SUM_WIDTH-1:0], m_tuser[0]);
				error_count++;
			end else begin
				want = pending_sums.pop_front();
				if (m_tdata[SUM_WIDTH-1:0] !== want.factor_sum) begin
					$error("factor_sum mismatch: expected %0d, actual %0d",
						want.factor_sum, m_tdata[SUM_WIDTH-1:0]);
					error_count++;
				end
				if (m_tuser[0] !== want.invalid) begin
					$error("invalid mismatch: expected %0d, actual %0d",
						want.invalid, m_tuser[0]);
					error_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	// On return s_tvalid is still high; the caller either sends again in the same step
	// or lowers it.
	task automatic send_number(input logic [IN_W-1:0] number);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= number;
		do @(posedge clk); while (!s_tready);
		pending_sums.push_back(predict_factor_sum(number, add_one_model));
	endtask

	task automatic wait_drain();
		s_tvalid <= 1'b0;
		while (pending_sums.size() != 0)
			@(posedge clk);
	endtask

	task automatic apb_write(input int reg_idx, input logic [APB_DATA_W-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_W'(reg_idx * 4);
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		if (reg_idx == REG_IDX_ADD_ONE)
			add_one_model = value[0];
	endtask

	task automatic check_add_one_reg();
		logic [APB_DATA_W-1:0] want;
		want = APB_DATA_W'(add_one_model);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= ADDR_W'(REG_IDX_ADD_ONE * 4);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== want) begin
			$error("add_one mismatch: expected %0h, actual %0h", want, prdata);
			error_count++;
		end
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic set_idling(input int tx_pct, input int rx_pct);
		tx_idle_pct = tx_pct;
		rx_stall_pct <= rx_pct;
	endtask

	task automatic test_register_reset();
		check_add_one_reg();
	endtask

	task automatic test_directed_numbers();
		logic [IN_W-1:0] numbers[16] = '{
			16'd0, 16'd1, 16'd2, 16'd3, 16'd4, 16'd6, 16'd9, 16'd49,
			16'd63001, 16'd65521, 16'd32768, 16'd65535, 16'd65534,
			16'h5555, 16'hAAAA, 16'd65025
		};
		foreach (numbers[i])
			send_number(numbers[i]);
		wait_drain();
	endtask

	task automatic test_add_one_cleared();
		apb_write(REG_IDX_ADD_ONE, 32'hFFFF_FFFE);
		check_add_one_reg();
		send_number(16'd0);
		send_number(16'd1);
		send_number(16'd2);
		send_number(16'd65521);
		wait_drain();
	endtask

	// A write to an unmapped address must leave add_one alone.
	task automatic test_unmapped_register();
		apb_write(REG_IDX_UNUSED, 32'hFFFF_FFFF);
		check_add_one_reg();
		send_number(16'd1);
		send_number(16'd3);
		wait_drain();
		apb_write(REG_IDX_ADD_ONE, 32'hFFFF_FFFF);
		check_add_one_reg();
	endtask

	task automatic test_backpressure();
		set_idling(0, 0);
		hold_req_id <= hold_req_id + 1;
		repeat (5)
			send_number(IN_W'($urandom_range(255, 2)));
		wait_drain();
		repeat (3)
			send_number(IN_W'($urandom_range(1023)));
		wait_drain();
	endtask

	task automatic test_random_traffic();
		int              phase;
		int              kind;
		int              w;
		int unsigned     prod;
		int unsigned     p;
		logic            more;
		logic [IN_W-1:0] n;
		for (phase = 0; phase < 4; phase++) begin
			case (phase)
				0: set_idling(0, 0);
				1: set_idling(72, 0);
				2: set_idling(0, 72);
				default: set_idling(24, 24);
			endcase
			apb_write(REG_IDX_ADD_ONE, {31'($urandom_range(32'h7FFF_FFFF)), phase[0]});
			repeat (RANDOM_PER_PHASE) begin
				kind = $urandom_range(99);
				if (kind < 5) begin
					n = '0;
				end else if (kind < 35) begin
					n = IN_W'($urandom_range(65535));
				end else if (kind < 65) begin
					w = $urandom_range(10, 1);
					n = IN_W'($urandom_range((1 << w) - 1));
				end else begin
					// Products of small primes exercise repeated factors.
					prod = 1;
					more = 1'b1;
					while (more) begin
						case ($urandom_range(5))
							0: p = 2;
							1: p = 3;
							2: p = 5;
							3: p = 7;
							4: p = 11;
							default: p = 13;
						endcase
						if (prod * p > 65535)
							more = 1'b0;
						else begin
							prod *= p;
							more = ($urandom_range(4) != 0);
						end
					end
					n = IN_W'(prod);
				end
				send_number(n);
			end
			wait_drain();
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_register_reset();
		test_directed_numbers();
		test_add_one_cleared();
		test_unmapped_register();
		test_backpressure();
		test_random_traffic();
		wait_drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
